@@ rtl/i2c_master_bit_sequencer_assert.svh @@
// assertion macros used by the i2c bit sequencer core
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CMS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define I2CMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cms_pkg.sv @@
// shared types and constants for the i2c bit sequencer
package i2cms_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int WR_END        = 3 * BITS_PER_BYTE;
  localparam int RD_LAST       = 1 + 2 * BITS_PER_BYTE;
  localparam int STEP_MAX      = 31;
  localparam int STEP_W        = 5;
  localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_WRITE   = 3'd4,
    CMD_READ    = 3'd5,
    CMD_WAITACK = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_byte;
    logic       sda_sample;
  } item_t;

endpackage

@@ rtl/i2cms_in_stage.sv @@
// input register stage holding one tick word
module i2cms_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  i2cms_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output i2cms_pkg::item_t item
);

  // register is free when empty or being drained this cycle
  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ rtl/i2cms_core.sv @@
// line state, one pin step per tick word, and the result register
`include "i2c_master_bit_sequencer_assert.svh"

module i2cms_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             item_valid,
  input  i2cms_pkg::item_t item,
  input  logic             out_stall,
  output logic             take,
  output logic             out_valid,
  output logic             scl_level,
  output logic             sda_level,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       read_byte,
  output logic             ack_seen,
  output logic             ack_timeout
);

  localparam int SW = i2cms_pkg::STEP_W;

  logic [7:0]      ack_wait_limit;
  i2cms_pkg::cmd_t cmd, cmd_next;
  logic [SW-1:0]   step, step_next;
  logic [1:0]      phase, phase_next;
  logic [7:0]      shift, shift_next;
  logic [7:0]      wait_cnt, wait_next;
  logic            scl, scl_next;
  logic            sda, sda_next;
  logic [7:0]      rd, rd_next;
  logic            ack_ok, ack_ok_next;
  logic            ack_late, ack_late_next;
  logic            step_last;
  logic            op_ok;

  assign take  = item_valid && (!out_valid || !out_stall);
  assign op_ok = (item.opcode >= i2cms_pkg::CMD_RELEASE) &&
                 (item.opcode <= i2cms_pkg::CMD_WAITACK);

  always_comb begin
    cmd_next      = cmd;
    step_next     = step;
    phase_next    = phase;
    shift_next    = shift;
    wait_next     = wait_cnt;
    scl_next      = scl;
    sda_next      = sda;
    rd_next       = rd;
    ack_ok_next   = ack_ok;
    ack_late_next = ack_late;
    step_last     = 1'b0;

    // idle block latches a new command and runs its first step now
    if (cmd == i2cms_pkg::CMD_NONE && op_ok) begin
      cmd_next   = i2cms_pkg::cmd_t'(item.opcode);
      step_next  = '0;
      phase_next = '0;
      wait_next  = '0;
      shift_next = (cmd_next == i2cms_pkg::CMD_WRITE) ? item.write_byte : 8'd0;
      if (cmd_next == i2cms_pkg::CMD_WAITACK) begin
        ack_ok_next   = 1'b0;
        ack_late_next = 1'b0;
      end
    end

    if (cmd_next != i2cms_pkg::CMD_NONE) begin
      unique case (cmd_next)
        i2cms_pkg::CMD_RELEASE: begin
          if (step_next == '0) begin
            sda_next = 1'b1;
          end else begin
            scl_next  = 1'b1;
            step_last = 1'b1;
          end
        end
        i2cms_pkg::CMD_START: begin
          if (step_next == '0) begin
            sda_next = 1'b1;
          end else if (step_next == SW'(1)) begin
            scl_next = 1'b1;
          end else begin
            sda_next  = 1'b0;
            step_last = 1'b1;
          end
        end
        i2cms_pkg::CMD_STOP: begin
          if (step_next == '0) begin
            sda_next = 1'b0;
          end else if (step_next == SW'(1)) begin
            scl_next = 1'b1;
          end else begin
            sda_next  = 1'b1;
            step_last = 1'b1;
          end
        end
        i2cms_pkg::CMD_WRITE: begin
          if (step_next < SW'(i2cms_pkg::WR_END)) begin
            // phase walks scl low, data, scl high for each bit
            if (phase_next == 2'd0) begin
              scl_next = 1'b0;
            end else if (phase_next == 2'd1) begin
              sda_next   = shift_next[7];
              shift_next = {shift_next[6:0], 1'b0};
            end else begin
              scl_next = 1'b1;
            end
            phase_next = (phase_next == 2'd2) ? 2'd0 : 2'(phase_next + 2'd1);
          end else if (step_next == SW'(i2cms_pkg::WR_END)) begin
            scl_next = 1'b0;
          end else begin
            sda_next  = 1'b1;
            step_last = 1'b1;
          end
        end
        i2cms_pkg::CMD_READ: begin
          if (step_next == '0) begin
            scl_next = 1'b0;
          end else if (step_next == SW'(1)) begin
            sda_next = 1'b1;
          end else if (!step_next[0]) begin
            scl_next = 1'b1;
          end else begin
            shift_next = {shift_next[6:0], item.sda_sample};
            scl_next   = 1'b0;
            if (step_next >= SW'(i2cms_pkg::RD_LAST)) begin
              rd_next   = shift_next;
              step_last = 1'b1;
            end
          end
        end
        i2cms_pkg::CMD_WAITACK: begin
          if (step_next == '0) begin
            scl_next = 1'b1;
          end else if (!item.sda_sample) begin
            ack_ok_next   = 1'b1;
            ack_late_next = 1'b0;
            scl_next      = 1'b0;
            step_last     = 1'b1;
          end else if (wait_next >= ack_wait_limit) begin
            ack_ok_next   = 1'b0;
            ack_late_next = 1'b1;
            scl_next      = 1'b0;
            step_last     = 1'b1;
          end else begin
            wait_next = 8'(wait_next + 8'd1);
          end
        end
        default: begin
          step_last = 1'b1;
        end
      endcase

      if (step_last) begin
        cmd_next  = i2cms_pkg::CMD_NONE;
        step_next = '0;
      end else if (step_next < SW'(i2cms_pkg::STEP_MAX) &&
                   !(cmd_next == i2cms_pkg::CMD_WAITACK && step_next != '0)) begin
        step_next = SW'(step_next + SW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit <= i2cms_pkg::ACK_LIMIT_RESET;
    end else if (cfg_write) begin
      ack_wait_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= i2cms_pkg::CMD_NONE;
      step      <= '0;
      phase     <= '0;
      shift     <= '0;
      wait_cnt  <= '0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      rd        <= '0;
      ack_ok    <= 1'b0;
      ack_late  <= 1'b0;
      done_res  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cmd       <= cmd_next;
        step      <= step_next;
        phase     <= phase_next;
        shift     <= shift_next;
        wait_cnt  <= wait_next;
        scl       <= scl_next;
        sda       <= sda_next;
        rd        <= rd_next;
        ack_ok    <= ack_ok_next;
        ack_late  <= ack_late_next;
        done_res  <= step_last;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign scl_level   = scl;
  assign sda_level   = sda;
  assign busy_res    = (cmd != i2cms_pkg::CMD_NONE);
  assign read_byte   = rd;
  assign ack_seen    = ack_ok;
  assign ack_timeout = ack_late;

  `I2CMS_ASSERT_NOW(a_done_not_busy, clk, rst, done_res, !busy_res, "done while still busy")
  `I2CMS_ASSERT_NOW(a_ack_excl, clk, rst, 1'b1, !(ack_ok && ack_late), "ack and timeout both set")
  `I2CMS_ASSERT_NOW(a_phase_range, clk, rst, 1'b1, phase != 2'd3, "write phase out of range")
  `I2CMS_ASSERT_NEXT(a_idle_hold, clk, rst, take && cmd == i2cms_pkg::CMD_NONE && !op_ok, $stable(scl) && $stable(sda) && !done_res, "idle word moved the lines")

endmodule

@@ rtl/i2c_master_bit_sequencer.sv @@
// i2c master bit sequencer: one pin step per tick word
// an accepted tick word waits in the input register until the core takes it; its
//   result word is then registered in the line state / result register
// throughput: one tick word per cycle while out_stall is low, set by the single step
//   of logic between the input register and the line state / result register
// reset (rst, synchronous): scl and sda released high, no command active, flags,
//   read byte and counters zero, ack wait limit 250
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  // tick word in
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [7:0] write_byte,
  input  logic       sda_sample,
  // result word out
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_byte,
  output logic       ack_seen,
  output logic       ack_timeout,
  // ack wait limit register
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);

  i2cms_pkg::item_t in_item;
  i2cms_pkg::item_t item;
  logic             item_valid;
  logic             take;

  // pack the tick word fields for the input register
  assign in_item.opcode     = opcode;
  assign in_item.write_byte = write_byte;
  assign in_item.sda_sample = sda_sample;

  // input register: takes a new word when empty or when the held one moves on
  i2cms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // sequencer: command latch, step counter, shifter, ack poll and
  // the line/status registers that form the result word
  i2cms_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item        (item),
    .out_stall   (out_stall),
    .take        (take),
    .out_valid   (out_valid),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .read_byte   (read_byte),
    .ack_seen    (ack_seen),
    .ack_timeout (ack_timeout)
  );

endmodule
